// ----- rtl/core/indexed_array_list_engine_macros.svh -----
// Assertion macros shared by the indexed array list engine RTL.
`ifndef INDEXED_ARRAY_LIST_ENGINE_MACROS_SVH
`define INDEXED_ARRAY_LIST_ENGINE_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define IALE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked implication, disabled while reset is asserted.
`define IALE_ASSERT_IMPL(label, ante, cons, msg) \
	`IALE_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ----- rtl/core/iale_pkg.sv -----
// Shared types and constants of the indexed array list engine.
package iale_pkg;

	localparam int DEF_CAPACITY = 256;
	// Position width that covers every supported capacity (up to 4096).
	localparam int POS_W = 13;
	localparam int IDX_W = 10;
	localparam int DATA_W = 32;
	localparam int ECNT_W = 9;

	typedef enum logic [2:0] {
		CMD_UPDATE = 3'd0,
		CMD_INSERT = 3'd1,
		CMD_DELETE = 3'd2,
		CMD_REMOVE = 3'd3,
		CMD_SWAP   = 3'd4,
		CMD_QUERY  = 3'd5,
		CMD_RSVD6  = 3'd6,
		CMD_RSVD7  = 3'd7
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_PASS
	} state_t;

	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_INSERT,
		MODE_DELETE,
		MODE_ROTATE
	} mode_t;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		mode_t              mode;
		logic [POS_W-1:0]   idx;
		logic [POS_W-1:0]   wpos;
		logic               wen;
		logic [DATA_W-1:0]  wval;
	} cell_ctl_t;

endpackage

// ----- rtl/core/iale_cell.sv -----
// One storage cell of the list chain.
module iale_cell #(
	parameter int INDEX = 0
) (
	input  logic                         clk,
	input  iale_pkg::cell_ctl_t          ctl,
	input  logic [iale_pkg::DATA_W-1:0]  left,
	input  logic [iale_pkg::DATA_W-1:0]  right,
	output logic [iale_pkg::DATA_W-1:0]  q
);

	localparam logic [iale_pkg::POS_W-1:0] MY_POS = iale_pkg::POS_W'(INDEX);

	logic [iale_pkg::DATA_W-1:0] data_q;
	logic [iale_pkg::DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctl.mode)
			iale_pkg::MODE_INSERT: begin
				if (MY_POS == ctl.idx) data_d = ctl.wval;
				else if (MY_POS > ctl.idx) data_d = left;
			end
			iale_pkg::MODE_DELETE: begin
				if (MY_POS >= ctl.idx) data_d = right;
			end
			iale_pkg::MODE_ROTATE: begin
				if (ctl.wen && MY_POS == ctl.wpos) data_d = ctl.wval;
				else data_d = right;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign q = data_q;

endmodule

// ----- rtl/core/iale_chain.sv -----
// Row of list cells, each linked to its two neighbors.
module iale_chain #(
	parameter int CAPACITY = iale_pkg::DEF_CAPACITY
) (
	input  logic                         clk,
	input  iale_pkg::cell_ctl_t          ctl,
	output logic [iale_pkg::DATA_W-1:0]  head
);

	logic [iale_pkg::DATA_W-1:0] cell_q [CAPACITY];

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [iale_pkg::DATA_W-1:0] lft;
		logic [iale_pkg::DATA_W-1:0] rgt;
		if (k == 0) begin : g_first
			assign lft = cell_q[k];
		end else begin : g_left
			assign lft = cell_q[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign rgt = cell_q[k];
		end else begin : g_right
			assign rgt = cell_q[k+1];
		end
		iale_cell #(.INDEX(k)) u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.left  (lft),
			.right (rgt),
			.q     (cell_q[k])
		);
	end

	assign head = cell_q[0];

endmodule

// ----- rtl/core/indexed_array_list_engine.sv -----
// Top level of the indexed array list engine: command control and result port.
`include "indexed_array_list_engine_macros.svh"

// The list lives in a row of CAPACITY cells; every cell sees a common control
// word and the contents of its two neighbors. A command transaction is taken
// when start is high and busy is low, and its single result is shown for one
// cycle with done high; the receiver cannot stall it. Insert and delete
// change the cells in the accepting cycle, while rejected and unused
// commands leave them unchanged; for all of these the result follows in
// the next cycle. Update, query and remove-by-value rotate the live
// entries once through the head cell, one entry per cycle; swap makes two
// such rotations (one to capture both entries, one to write them back).
// Remove compacts the list during its rotation by writing each kept entry
// behind the ones already kept. entry_count shows the low 9 bits of the
// count after the command.
module indexed_array_list_engine #(
	parameter int CAPACITY = iale_pkg::DEF_CAPACITY
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    cmd,
	input  logic [iale_pkg::IDX_W-1:0]    first_index,
	input  logic [iale_pkg::IDX_W-1:0]    second_index,
	input  logic signed [31:0]            operand_value,
	output logic                          done,
	output logic                          status,
	output logic signed [31:0]            read_value,
	output logic [iale_pkg::ECNT_W-1:0]   entry_count
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = iale_pkg::POS_W;
	localparam logic [PW-1:0] CAP_POS = PW'(CAPACITY);

	iale_pkg::state_t state_q, state_d;

	logic [CW-1:0]  cnt_q, cnt_d;
	logic [CW-1:0]  t_q, t_d;
	logic [CW-1:0]  w_q, w_d;
	logic           second_q, second_d;
	iale_pkg::cmd_t op_q, op_d;
	logic [iale_pkg::IDX_W-1:0] i1_q, i1_d, i2_q, i2_d;
	logic [31:0]    val_q, val_d;
	logic [31:0]    a_q, a_d, b_q, b_d;

	logic           done_q, done_d;
	logic           status_q, status_d;
	logic [31:0]    rdval_q, rdval_d;

	logic [31:0]    head;
	iale_pkg::cell_ctl_t ctl;

	logic           accept;
	logic           cmd_ok;
	logic           needs_pass;
	logic           keep;
	logic           last_step;
	logic           hit1, hit2;
	logic [PW-1:0]  n_pos, i1_in, i2_in, t_pos;
	logic [CW-1:0]  w_inc;

	assign accept = start && !busy;
	assign busy   = (state_q != iale_pkg::ST_IDLE);

	assign n_pos = PW'(cnt_q);
	assign i1_in = PW'(first_index);
	assign i2_in = PW'(second_index);
	assign t_pos = PW'(t_q);

	// Checks that need only the incoming command and the current count.
	always_comb begin
		cmd_ok     = 1'b1;
		needs_pass = 1'b0;
		case (iale_pkg::cmd_t'(cmd))
			iale_pkg::CMD_UPDATE, iale_pkg::CMD_QUERY: begin
				cmd_ok     = (i1_in < n_pos);
				needs_pass = cmd_ok;
			end
			iale_pkg::CMD_SWAP: begin
				cmd_ok     = (i1_in < n_pos) && (i2_in < n_pos);
				needs_pass = cmd_ok;
			end
			iale_pkg::CMD_INSERT: cmd_ok = (i1_in <= n_pos) && (n_pos < CAP_POS);
			iale_pkg::CMD_DELETE: cmd_ok = (i1_in < n_pos);
			iale_pkg::CMD_REMOVE: begin
				cmd_ok     = (cnt_q != '0);
				needs_pass = cmd_ok;
			end
			default: cmd_ok = 1'b1;
		endcase
	end

	// Per-step view of the rotation in progress.
	assign hit1      = (PW'(i1_q) == t_pos);
	assign hit2      = (PW'(i2_q) == t_pos);
	assign last_step = (t_pos == n_pos - PW'(1));
	assign keep      = (op_q != iale_pkg::CMD_REMOVE) || (head != val_q);
	assign w_inc     = w_q + CW'(keep);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iale_pkg::ST_IDLE: if (accept && needs_pass) state_d = iale_pkg::ST_PASS;
			iale_pkg::ST_PASS: begin
				if (last_step && !(op_q == iale_pkg::CMD_SWAP && !second_q))
					state_d = iale_pkg::ST_IDLE;
			end
			default: state_d = iale_pkg::ST_IDLE;
		endcase
	end

	// Cell control and datapath registers.
	always_comb begin
		ctl.mode = iale_pkg::MODE_HOLD;
		ctl.idx  = i1_in;
		ctl.wpos = n_pos - PW'(1) - t_pos + PW'(w_q);
		ctl.wen  = keep;
		ctl.wval = head;

		cnt_d    = cnt_q;
		t_d      = t_q;
		w_d      = w_q;
		second_d = second_q;
		op_d     = op_q;
		i1_d     = i1_q;
		i2_d     = i2_q;
		val_d    = val_q;
		a_d      = a_q;
		b_d      = b_q;
		done_d   = 1'b0;
		status_d = status_q;
		rdval_d  = rdval_q;

		unique case (state_q)
			iale_pkg::ST_IDLE: begin
				if (accept) begin
					op_d     = iale_pkg::cmd_t'(cmd);
					i1_d     = first_index;
					i2_d     = second_index;
					val_d    = operand_value;
					t_d      = '0;
					w_d      = '0;
					second_d = 1'b0;
					if (!needs_pass) begin
						done_d   = 1'b1;
						status_d = !cmd_ok;
						rdval_d  = '0;
						if (cmd_ok && iale_pkg::cmd_t'(cmd) == iale_pkg::CMD_INSERT) begin
							ctl.mode = iale_pkg::MODE_INSERT;
							ctl.wval = operand_value;
							cnt_d    = cnt_q + CW'(1);
						end else if (cmd_ok &&
						             iale_pkg::cmd_t'(cmd) == iale_pkg::CMD_DELETE) begin
							ctl.mode = iale_pkg::MODE_DELETE;
							cnt_d    = cnt_q - CW'(1);
						end
					end
				end
			end
			iale_pkg::ST_PASS: begin
				ctl.mode = iale_pkg::MODE_ROTATE;
				case (op_q)
					iale_pkg::CMD_UPDATE: if (hit1) ctl.wval = val_q;
					iale_pkg::CMD_QUERY: if (hit1) a_d = head;
					iale_pkg::CMD_SWAP: begin
						if (!second_q) begin
							if (hit1) a_d = head;
							if (hit2) b_d = head;
						end else if (hit1) begin
							ctl.wval = b_q;
						end else if (hit2) begin
							ctl.wval = a_q;
						end
					end
					default: ;
				endcase
				t_d = t_q + CW'(1);
				w_d = w_inc;
				if (last_step) begin
					t_d = '0;
					w_d = '0;
					if (op_q == iale_pkg::CMD_SWAP && !second_q) begin
						second_d = 1'b1;
					end else begin
						done_d   = 1'b1;
						status_d = 1'b0;
						rdval_d  = '0;
						if (op_q == iale_pkg::CMD_QUERY) rdval_d = hit1 ? head : a_q;
						if (op_q == iale_pkg::CMD_REMOVE) begin
							// No equal entry means a full rotation kept everything.
							status_d = (w_inc == cnt_q);
							cnt_d    = w_inc;
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= iale_pkg::ST_IDLE;
			cnt_q    <= '0;
			done_q   <= 1'b0;
			t_q      <= '0;
			w_q      <= '0;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			done_q   <= done_d;
			t_q      <= t_d;
			w_q      <= w_d;
			second_q <= second_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		i1_q     <= i1_d;
		i2_q     <= i2_d;
		val_q    <= val_d;
		a_q      <= a_d;
		b_q      <= b_d;
		status_q <= status_d;
		rdval_q  <= rdval_d;
	end

	iale_chain #(.CAPACITY(CAPACITY)) u_chain (
		.clk  (clk),
		.ctl  (ctl),
		.head (head)
	);

	assign done        = done_q;
	assign status      = status_q;
	assign read_value  = rdval_q;
	assign entry_count = iale_pkg::ECNT_W'(cnt_q);

	`IALE_ASSERT_IMPL(a_done_idle, done_q, state_q == iale_pkg::ST_IDLE, "result while busy")
	`IALE_ASSERT(a_cnt_cap, PW'(cnt_q) <= CAP_POS, "count above capacity")
	`IALE_ASSERT_IMPL(a_reject_keeps_cnt, done_q && status_q, $stable(cnt_q), "reject moved count")
	`IALE_ASSERT_IMPL(a_pass_in_range, state_q == iale_pkg::ST_PASS, t_pos < n_pos, "step beyond list")

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the indexed array list engine.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = iale_pkg::DEF_CAPACITY;
	localparam int RANDOM_ITEMS = 600;
	// Longest command is a swap on a full list, which makes two rotations.
	localparam int MAX_LATENCY = 2 * CAPACITY + 8;
	localparam int CYCLE_LIMIT = 1_000_000;

	// One result transaction as seen on the result ports.
	typedef struct {
		logic              status;
		logic signed [31:0] read_value;
		logic [8:0]        entry_count;
	} list_result_t;

	// One row of the directed stimulus. When has_typed is set, the expected
	// result is written in the row; otherwise the list predictor supplies it.
	typedef struct {
		iale_pkg::cmd_t    op;
		logic [9:0]        first_index;
		logic [9:0]        second_index;
		logic signed [31:0] operand_value;
		bit                has_typed;
		logic              status;
		logic signed [31:0] read_value;
		logic [8:0]        entry_count;
	} directed_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [2:0]        cmd;
	logic [9:0]        first_index;
	logic [9:0]        second_index;
	logic signed [31:0] operand_value;
	logic              done;
	logic              status;
	logic signed [31:0] read_value;
	logic [8:0]        entry_count;

	// Predicted contents of the list, in list index order.
	logic signed [31:0] list_image[$];
	// Results that the engine still owes, oldest first.
	list_result_t pending_results[$];

	int unsigned mismatches;
	int unsigned cycle_count;
	int unsigned commands_sent;
	int unsigned results_seen;
	int unsigned peak_count;
	int unsigned rejected_seen;
	bit          idle_enable;

	directed_row_t directed_rows[];

	indexed_array_list_engine #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.first_index(first_index),
		.second_index(second_index),
		.operand_value(operand_value),
		.done(done),
		.status(status),
		.read_value(read_value),
		.entry_count(entry_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Prints one line for a mismatch and counts it.
	task automatic report_mismatch(input string what);
		mismatches++;
		$display("[%0t] MISMATCH: %s", $realtime, what);
	endtask

	// Applies one accepted command to the predicted list and returns the
	// result that the engine must produce for it.
	function automatic list_result_t apply_command(input iale_pkg::cmd_t op,
			input logic [9:0] idx_a, input logic [9:0] idx_b,
			input logic signed [31:0] value);
		list_result_t res;
		logic signed [31:0] held;
		int unsigned before_size;
		int unsigned live;
		live = list_image.size();
		res.status = 1'b0;
		res.read_value = '0;
		case (op)
			iale_pkg::CMD_UPDATE: begin
				if (idx_a < live)
					list_image[idx_a] = value;
				else
					res.status = 1'b1;
			end
			iale_pkg::CMD_INSERT: begin
				// An index equal to the count appends; a full list rejects.
				if (idx_a <= live && live < CAPACITY)
					list_image.insert(idx_a, value);
				else
					res.status = 1'b1;
			end
			iale_pkg::CMD_DELETE: begin
				if (idx_a < live)
					list_image.delete(idx_a);
				else
					res.status = 1'b1;
			end
			iale_pkg::CMD_REMOVE: begin
				// Every equal entry goes; finding none is a rejection.
				before_size = live;
				list_image = list_image.find(x) with (x != value);
				if (list_image.size() == before_size)
					res.status = 1'b1;
			end
			iale_pkg::CMD_SWAP: begin
				if (idx_a < live && idx_b < live) begin
					held = list_image[idx_a];
					list_image[idx_a] = list_image[idx_b];
					list_image[idx_b] = held;
				end else begin
					res.status = 1'b1;
				end
			end
			iale_pkg::CMD_QUERY: begin
				if (idx_a < live)
					res.read_value = list_image[idx_a];
				else
					res.status = 1'b1;
			end
			default: ; // The unused codes change nothing and report done.
		endcase
		res.entry_count = 9'(list_image.size());
		return res;
	endfunction

	// Drives one command transaction, optionally after a random idle burst,
	// and waits for the rising edge at which the engine takes it.
	task automatic issue_command(input iale_pkg::cmd_t op, input logic [9:0] idx_a,
			input logic [9:0] idx_b, input logic signed [31:0] value,
			input bit has_typed, input list_result_t typed);
		int unsigned gap;
		list_result_t predicted;
		gap = 0;
		if (idle_enable && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 5);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		cmd <= op;
		first_index <= idx_a;
		second_index <= idx_b;
		operand_value <= value;
		// The transaction is taken at the first rising edge with busy low.
		do
			@(posedge clk);
		while (busy);
		predicted = apply_command(op, idx_a, idx_b, value);
		pending_results.push_back(has_typed ? typed : predicted);
		commands_sent++;
		if (list_image.size() > peak_count)
			peak_count = list_image.size();
	endtask

	// Result checker: every strobe must match the oldest expectation.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (status)
				rejected_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: status %0b count %0d",
					status, entry_count));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status)
					report_mismatch($sformatf("status %0b, expected %0b",
						status, want.status));
				if (read_value !== want.read_value)
					report_mismatch($sformatf("read_value %0d, expected %0d",
						read_value, want.read_value));
				if (entry_count !== want.entry_count)
					report_mismatch($sformatf("entry_count %0d, expected %0d",
						entry_count, want.entry_count));
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding",
				cycle_count, pending_results.size());
			$display("indexed_array_list_engine regression: fail");
			$finish;
		end
	end

	// Picks a random command code, weighted by the phase of the run. The
	// growing phase favors inserts so that the list grows; the shrinking
	// phase drains it with deletes and removes.
	function automatic iale_pkg::cmd_t pick_command(input bit growing);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (growing) begin
			if (roll < 55) return iale_pkg::CMD_INSERT;
			if (roll < 63) return iale_pkg::CMD_UPDATE;
			if (roll < 71) return iale_pkg::CMD_DELETE;
			if (roll < 76) return iale_pkg::CMD_REMOVE;
			if (roll < 84) return iale_pkg::CMD_SWAP;
			if (roll < 96) return iale_pkg::CMD_QUERY;
		end else begin
			if (roll < 15) return iale_pkg::CMD_INSERT;
			if (roll < 21) return iale_pkg::CMD_UPDATE;
			if (roll < 51) return iale_pkg::CMD_DELETE;
			if (roll < 71) return iale_pkg::CMD_REMOVE;
			if (roll < 81) return iale_pkg::CMD_SWAP;
			if (roll < 96) return iale_pkg::CMD_QUERY;
		end
		return ($urandom_range(0, 1) != 0) ? iale_pkg::CMD_RSVD6 : iale_pkg::CMD_RSVD7;
	endfunction

	// Mostly a position near the live range, sometimes anywhere in 10 bits
	// so that out-of-range indices and every index bit are exercised.
	function automatic logic [9:0] pick_index();
		if ($urandom_range(0, 9) == 0)
			return 10'($urandom_range(0, 1023));
		return 10'($urandom_range(0, list_image.size()));
	endfunction

	// Values come from a small pool so that removes find duplicates, or from
	// the full 32-bit range so that every value bit toggles.
	function automatic logic signed [31:0] pick_value(input iale_pkg::cmd_t op);
		if (op == iale_pkg::CMD_REMOVE && list_image.size() != 0 &&
		    $urandom_range(0, 9) < 7)
			return list_image[$urandom_range(0, list_image.size() - 1)];
		if ($urandom_range(0, 1) != 0)
			return $signed($urandom_range(0, 6)) - 3;
		return $urandom();
	endfunction

	initial begin
		list_result_t typed;
		iale_pkg::cmd_t op;
		logic signed [31:0] max_pos;
		logic signed [31:0] max_neg;
		int unsigned drain_wait;

		max_pos = 32'sh7fff_ffff;
		max_neg = 32'sh8000_0000;
		mismatches = 0;
		cycle_count = 0;
		commands_sent = 0;
		results_seen = 0;
		peak_count = 0;
		rejected_seen = 0;
		idle_enable = 1'b1;

		arst_n = 1'b0;
		start = 1'b0;
		cmd = iale_pkg::CMD_UPDATE;
		first_index = '0;
		second_index = '0;
		operand_value = '0;

		// Directed part. The first rows hit the empty list, where every
		// indexed command and a remove must be rejected, and the unused codes.
		// Then two extreme values are loaded and read back.
		directed_rows = '{
			'{iale_pkg::CMD_QUERY,  10'd0,    10'd0,    32'sd0,  1'b1, 1'b1, 32'sd0,  9'd0},
			'{iale_pkg::CMD_DELETE, 10'd0,    10'd0,    32'sd0,  1'b1, 1'b1, 32'sd0,  9'd0},
			'{iale_pkg::CMD_UPDATE, 10'd0,    10'd0,    32'sd9,  1'b1, 1'b1, 32'sd0,  9'd0},
			'{iale_pkg::CMD_SWAP,   10'd0,    10'd0,    32'sd0,  1'b1, 1'b1, 32'sd0,  9'd0},
			'{iale_pkg::CMD_REMOVE, 10'd0,    10'd0,    32'sd5,  1'b1, 1'b1, 32'sd0,  9'd0},
			'{iale_pkg::CMD_RSVD6,  10'd1023, 10'd1023, -32'sd1, 1'b1, 1'b0, 32'sd0,  9'd0},
			'{iale_pkg::CMD_RSVD7,  10'd0,    10'd0,    32'sd0,  1'b1, 1'b0, 32'sd0,  9'd0},
			'{iale_pkg::CMD_INSERT, 10'd0,    10'd0,    max_pos, 1'b1, 1'b0, 32'sd0,  9'd1},
			'{iale_pkg::CMD_INSERT, 10'd5,    10'd0,    32'sd1,  1'b1, 1'b1, 32'sd0,  9'd1},
			'{iale_pkg::CMD_INSERT, 10'd1,    10'd0,    max_neg, 1'b1, 1'b0, 32'sd0,  9'd2},
			'{iale_pkg::CMD_QUERY,  10'd0,    10'd0,    32'sd0,  1'b1, 1'b0, max_pos, 9'd2},
			'{iale_pkg::CMD_QUERY,  10'd1,    10'd0,    32'sd0,  1'b1, 1'b0, max_neg, 9'd2},
			'{iale_pkg::CMD_QUERY,  10'd1023, 10'd0,    32'sd0,  1'b1, 1'b1, 32'sd0,  9'd2},
			'{iale_pkg::CMD_SWAP,   10'd0,    10'd1,    32'sd0,  1'b1, 1'b0, 32'sd0,  9'd2},
			'{iale_pkg::CMD_QUERY,  10'd0,    10'd0,    32'sd0,  1'b0, 1'b0, 32'sd0,  9'd0},
			'{iale_pkg::CMD_UPDATE, 10'd1023, 10'd0,    32'sd7,  1'b1, 1'b1, 32'sd0,  9'd2},
			'{iale_pkg::CMD_UPDATE, 10'd0,    10'd0,    -32'sd1, 1'b0, 1'b0, 32'sd0,  9'd0},
			'{iale_pkg::CMD_INSERT, 10'd0,    10'd0,    -32'sd1, 1'b0, 1'b0, 32'sd0,  9'd0},
			'{iale_pkg::CMD_REMOVE, 10'd0,    10'd0,    -32'sd1, 1'b0, 1'b0, 32'sd0,  9'd0},
			'{iale_pkg::CMD_DELETE, 10'd1023, 10'd0,    32'sd0,  1'b1, 1'b1, 32'sd0,  9'd1},
			'{iale_pkg::CMD_SWAP,   10'd0,    10'd1023, 32'sd0,  1'b1, 1'b1, 32'sd0,  9'd1},
			'{iale_pkg::CMD_DELETE, 10'd0,    10'd0,    32'sd0,  1'b0, 1'b0, 32'sd0,  9'd0},
			'{iale_pkg::CMD_QUERY,  10'd0,    10'd0,    32'sd0,  1'b1, 1'b1, 32'sd0,  9'd0}
		};

		// Reset is held and then released away from a clock edge.
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[r]) begin
			typed.status = directed_rows[r].status;
			typed.read_value = directed_rows[r].read_value;
			typed.entry_count = directed_rows[r].entry_count;
			issue_command(directed_rows[r].op, directed_rows[r].first_index,
				directed_rows[r].second_index, directed_rows[r].operand_value,
				directed_rows[r].has_typed, typed);
		end

		// Random part. The list grows for the first stretch and shrinks after
		// it; the last hundred transactions go back to back with no idling.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			idle_enable = (n < RANDOM_ITEMS - 100);
			op = pick_command(n < 380);
			issue_command(op, pick_index(), pick_index(), pick_value(op), 1'b0, typed);
		end

		@(negedge clk);
		start <= 1'b0;

		// Wait for the last results, then a little longer for any stray one.
		drain_wait = 0;
		while (pending_results.size() != 0 && drain_wait < 4 * MAX_LATENCY) begin
			@(posedge clk);
			drain_wait++;
		end
		repeat (MAX_LATENCY) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

		$display("Ran %0d command transactions (%0d results, %0d rejected).",
			commands_sent, results_seen, rejected_seen);
		$display("The list peaked at %0d of %0d entries; %0d mismatches.",
			peak_count, CAPACITY, mismatches);
		if (mismatches == 0)
			$display("indexed_array_list_engine regression: pass");
		else
			$display("indexed_array_list_engine regression: fail");
		$finish;
	end

endmodule
